// ===== design/fcw_pkg.sv =====
// Shared types, constants and a helper function of the FAT16 cluster chain walker.
`default_nettype none

package fcw_pkg;

    localparam logic [15:0] CHAIN_END   = 16'hFFF8;
    localparam logic [15:0] MIN_CLUSTER = 16'd2;
    localparam logic [15:0] END_MARK    = 16'hFFFF;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;
    localparam int SECTOR_W   = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_DATA_START      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_SECTORS = 1'b1;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_WALK  = 1'b1;

    typedef struct packed {
        logic ram_we;
        logic issue_start;
        logic issue_next;
        logic load_out;
        logic load_empty;
        logic out_trunc;
        logic out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic start_ok;
        logic more;
    } t_dp_sts;

    function automatic logic in_chain(input logic [15:0] c);
        return (c >= MIN_CLUSTER) && (c < CHAIN_END);
    endfunction

endpackage

`default_nettype wire

// ===== design/fcw_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module fcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/fcw_ctrl.sv =====
// Controller state machine that sequences table writes and chain walks.
`default_nettype none

module fcw_ctrl
    import fcw_pkg::*;
#(
    parameter int MAX_RUN = 64
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire logic    i_cmd,
    output logic         o_ready,
    output logic         o_valid,
    input  wire logic    i_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    localparam int RW = $clog2(MAX_RUN + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LOAD  = 2'd1;
    localparam logic [1:0] S_EMPTY = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [RW-1:0] r_run, n_run;
    logic          r_out_valid, n_out_valid;
    logic          out_free;
    logic          accept;
    logic          cut;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign cut      = i_sts.more && (r_run == RW'(MAX_RUN - 1));
    assign o_valid  = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_run   = r_run;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd == CMD_WRITE) begin
                        o_cmd.ram_we = 1'b1;
                    end else begin
                        o_cmd.issue_start = 1'b1;
                        n_run = '0;
                        n_state = i_sts.start_ok ? S_LOAD : S_EMPTY;
                    end
                end
            end
            S_LOAD: begin
                if (out_free) begin
                    o_cmd.load_out  = 1'b1;
                    o_cmd.out_trunc = cut;
                    o_cmd.out_last  = !i_sts.more || cut;
                    n_run = r_run + RW'(1);
                    if (!i_sts.more || cut) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.issue_next = 1'b1;
                    end
                end
            end
            S_EMPTY: begin
                if (out_free) begin
                    o_cmd.load_empty = 1'b1;
                    n_run = RW'(1);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_out || o_cmd.load_empty) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_run       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_run       <= n_run;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ===== design/fcw_datapath.sv =====
// Datapath with configuration registers, table memory, sector arithmetic and result register.
`default_nettype none

module fcw_datapath
    import fcw_pkg::*;
#(
    parameter int TABLE_ENTRIES = 65536
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [15:0]           i_cluster,
    input  wire logic [15:0]           i_value,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_sts                    o_sts,
    output logic [SECTOR_W-1:0]        o_sector_address,
    output logic [15:0]                o_current_cluster,
    output logic [15:0]                o_next_cluster,
    output logic                       o_empty_res,
    output logic                       o_truncated,
    output logic                       o_last
);

    localparam int AW = $clog2(TABLE_ENTRIES);

    logic [19:0]         r_data_start;
    logic [7:0]          r_cluster_sectors;
    logic [15:0]         r_cur;
    logic [SECTOR_W-1:0] r_prod;
    logic                r_oor;
    logic [SECTOR_W-1:0] r_sector;
    logic [15:0]         r_out_cur;
    logic [15:0]         r_out_next;
    logic                r_empty;
    logic                r_trunc;
    logic                r_last;

    logic [15:0]         ram_rdata;
    logic [15:0]         nxt;
    logic [15:0]         src;
    logic [15:0]         diff;
    logic                wr_in_range;
    logic                src_in_range;
    logic                rd_en;

    assign wr_in_range  = {1'b0, i_cluster} < 17'(TABLE_ENTRIES);
    assign rd_en        = i_cmd.issue_start || i_cmd.issue_next;
    assign src          = i_cmd.issue_start ? i_cluster : nxt;
    assign src_in_range = {1'b0, src} < 17'(TABLE_ENTRIES);
    assign diff         = src - MIN_CLUSTER;
    assign nxt          = r_oor ? END_MARK : ram_rdata;

    assign o_sts.start_ok = in_chain(i_cluster);
    assign o_sts.more     = in_chain(nxt);

    fcw_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we && wr_in_range),
        .i_waddr (i_cluster[AW-1:0]),
        .i_wdata (i_value),
        .i_re    (rd_en),
        .i_raddr (src[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_start      <= '0;
            r_cluster_sectors <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DATA_START:      r_data_start      <= i_cfg_data;
                CFG_CLUSTER_SECTORS: r_cluster_sectors <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_cur  <= src;
            r_oor  <= !src_in_range;
            r_prod <= SECTOR_W'({8'b0, diff} * {16'b0, r_cluster_sectors});
        end
        if (i_cmd.load_out) begin
            r_sector   <= {4'b0, r_data_start} + r_prod;
            r_out_cur  <= r_cur;
            r_out_next <= nxt;
            r_empty    <= 1'b0;
            r_trunc    <= i_cmd.out_trunc;
            r_last     <= i_cmd.out_last;
        end else if (i_cmd.load_empty) begin
            r_sector   <= '0;
            r_out_cur  <= r_cur;
            r_out_next <= '0;
            r_empty    <= 1'b1;
            r_trunc    <= 1'b0;
            r_last     <= 1'b1;
        end
    end

    assign o_sector_address  = r_sector;
    assign o_current_cluster = r_out_cur;
    assign o_next_cluster    = r_out_next;
    assign o_empty_res       = r_empty;
    assign o_truncated       = r_trunc;
    assign o_last            = r_last;

endmodule

`default_nettype wire

// ===== design/fat16_cluster_chain_walker_unit.sv =====
// Top level of the FAT16 cluster chain walker: controller plus datapath.
// A table write word is taken in the idle state; the block is ready again the next cycle.
// A walk's first result passes the table read register, then the result register; later
// results come one per cycle while the receiver takes them; the read port sets this pace.
// Reset clears controller, output valid flag, data start; sectors per cluster goes to 1.
// The table memory is not cleared by reset and holds its contents until rewritten.
`default_nettype none

module fat16_cluster_chain_walker_unit
    import fcw_pkg::*;
#(
    parameter int TABLE_ENTRIES = 65536,
    parameter int MAX_RUN       = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_cmd,
    input  wire logic [15:0]           i_cluster,
    input  wire logic [15:0]           i_value,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [SECTOR_W-1:0]        o_sector_address,
    output logic [15:0]                o_current_cluster,
    output logic [15:0]                o_next_cluster,
    output logic                       o_empty_res,
    output logic                       o_truncated,
    output logic                       o_last
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    fcw_ctrl #(
        .MAX_RUN (MAX_RUN)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (i_cmd),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd)
    );

    fcw_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_cluster         (i_cluster),
        .i_value           (i_value),
        .i_cmd             (dp_cmd),
        .o_sts             (dp_sts),
        .o_sector_address  (o_sector_address),
        .o_current_cluster (o_current_cluster),
        .o_next_cluster    (o_next_cluster),
        .o_empty_res       (o_empty_res),
        .o_truncated       (o_truncated),
        .o_last            (o_last)
    );

endmodule

`default_nettype wire

// ===== design/fcw_checker.sv =====
// Port-level assertions for the chain walker and the bind that attaches them.
`default_nettype none

module fcw_checker
    import fcw_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_valid,
    input wire logic                i_ready,
    input wire logic [SECTOR_W-1:0] o_sector_address,
    input wire logic [15:0]         o_current_cluster,
    input wire logic [15:0]         o_next_cluster,
    input wire logic                o_empty_res,
    input wire logic                o_truncated,
    input wire logic                o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sector_address)
            && $stable(o_current_cluster) && $stable(o_next_cluster) && $stable(o_last))
        else $error("result word changed while stalled");

    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_empty_res |-> o_last && !o_truncated
            && (o_sector_address == '0) && (o_next_cluster == '0))
        else $error("empty result has wrong form");

    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_truncated |-> o_last && in_chain(o_next_cluster))
        else $error("truncated result is not a final word with a resume point");

    a_mid_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> in_chain(o_next_cluster) && in_chain(o_current_cluster))
        else $error("walk continues past an end of chain");

endmodule

bind fat16_cluster_chain_walker_unit fcw_checker u_fcw_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_sector_address  (o_sector_address),
    .o_current_cluster (o_current_cluster),
    .o_next_cluster    (o_next_cluster),
    .o_empty_res       (o_empty_res),
    .o_truncated       (o_truncated),
    .o_last            (o_last)
);

`default_nettype wire

// ===== tb/tb_fat16_cluster_chain_walker_unit.sv =====
// Testbench for the FAT16 cluster chain walker: directed table, random chains, scoreboard.
`timescale 1ns / 1ps

module tb_fat16_cluster_chain_walker_unit;
    import fcw_pkg::*;

    localparam int WALK_LIMIT = 64;
    localparam int HOLD_CYCLES = 500;
    localparam int PHASE_ITEMS = 60;
    localparam int NUM_PHASES = 6;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic [23:0] sector;
        logic [15:0] cur;
        logic [15:0] nxt;
        logic        empty;
        logic        trunc;
        logic        last;
    } t_run_rec;

    typedef struct packed {
        logic     typed;
        t_run_rec rec;
    } t_typed_word;

    typedef struct packed {
        logic        cmd;
        logic [15:0] cluster;
        logic [15:0] value;
        logic        typed;
        t_run_rec    rec;
    } t_plan_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic                  i_cmd = 1'b0;
    logic [15:0]           i_cluster = '0;
    logic [15:0]           i_value = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [SECTOR_W-1:0]   o_sector_address;
    logic [15:0]           o_current_cluster;
    logic [15:0]           o_next_cluster;
    logic                  o_empty_res;
    logic                  o_truncated;
    logic                  o_last;

    fat16_cluster_chain_walker_unit #(
        .TABLE_ENTRIES(65536),
        .MAX_RUN(WALK_LIMIT)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_cmd(i_cmd),
        .i_cluster(i_cluster),
        .i_value(i_value),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_sector_address(o_sector_address),
        .o_current_cluster(o_current_cluster),
        .o_next_cluster(o_next_cluster),
        .o_empty_res(o_empty_res),
        .o_truncated(o_truncated),
        .o_last(o_last)
    );

    t_plan_row opening_rows [0:19] = '{
        '{CMD_WALK,  16'h0000, 16'hFFFF, 1'b1, '{24'h0, 16'h0000, 16'h0, 1'b1, 1'b0, 1'b1}},
        '{CMD_WALK,  16'h0001, 16'h0000, 1'b1, '{24'h0, 16'h0001, 16'h0, 1'b1, 1'b0, 1'b1}},
        '{CMD_WALK,  16'hFFF8, 16'h5A5A, 1'b1, '{24'h0, 16'hFFF8, 16'h0, 1'b1, 1'b0, 1'b1}},
        '{CMD_WALK,  16'hFFFF, 16'hA5A5, 1'b1, '{24'h0, 16'hFFFF, 16'h0, 1'b1, 1'b0, 1'b1}},
        '{CMD_WRITE, 16'h0002, 16'hFFFF, 1'b0, '0},
        '{CMD_WALK,  16'h0002, 16'h0000, 1'b1, '{24'h0, 16'h0002, 16'hFFFF, 1'b0, 1'b0, 1'b1}},
        '{CMD_WRITE, 16'hFFF7, 16'hFFF8, 1'b0, '0},
        '{CMD_WALK,  16'hFFF7, 16'hFFFF, 1'b1,
          '{24'h00FFF5, 16'hFFF7, 16'hFFF8, 1'b0, 1'b0, 1'b1}},
        '{CMD_WRITE, 16'h0003, 16'hFFF0, 1'b0, '0},
        '{CMD_WRITE, 16'hFFF0, 16'h0000, 1'b0, '0},
        '{CMD_WALK,  16'h0003, 16'h1111, 1'b0, '0},
        '{CMD_WRITE, 16'h0004, 16'h0001, 1'b0, '0},
        '{CMD_WALK,  16'h0004, 16'h0000, 1'b1, '{24'h2, 16'h0004, 16'h0001, 1'b0, 1'b0, 1'b1}},
        '{CMD_WRITE, 16'h0005, 16'h0005, 1'b0, '0},
        '{CMD_WALK,  16'h0005, 16'h0000, 1'b0, '0},
        '{CMD_WRITE, 16'h0000, 16'h1234, 1'b0, '0},
        '{CMD_WRITE, 16'hFFFF, 16'hABCD, 1'b0, '0},
        '{CMD_WRITE, 16'h0006, 16'h0007, 1'b0, '0},
        '{CMD_WRITE, 16'h0007, 16'h0006, 1'b0, '0},
        '{CMD_WALK,  16'h0006, 16'hFFFF, 1'b0, '0}
    };

    t_idle_mode idle_mode = IDLE_NONE;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int items_sent = 0;
    int errors = 0;

    logic [15:0] plan_fat [0:65535];
    bit          plan_known [0:65535];
    logic [15:0] known_list [$];
    t_typed_word typed_q [$];

    logic [15:0] mirror_fat [0:65535];
    logic [19:0] mirror_start = 20'd0;
    logic [7:0]  mirror_spc = 8'd1;
    t_run_rec    pending_runs [$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic bit is_link(input logic [15:0] c);
        return (c >= MIN_CLUSTER) && (c < CHAIN_END);
    endfunction

    function automatic bit roll(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            case (idle_mode)
                IDLE_RECEIVER: i_ready <= !roll(86);
                IDLE_BOTH:     i_ready <= !roll(36);
                default:       i_ready <= 1'b1;
            endcase
        end
    end

    task automatic trace_chain(input logic [15:0] start);
        logic [15:0] pos;
        logic [15:0] link;
        logic [31:0] sect;
        t_run_rec    rec;
        bit          more;
        if (!is_link(start)) begin
            rec = '{sector: 24'h0, cur: start, nxt: 16'h0, empty: 1'b1, trunc: 1'b0,
                    last: 1'b1};
            pending_runs.push_back(rec);
            return;
        end
        pos = start;
        for (int n = 0; n < WALK_LIMIT; n++) begin
            sect = 32'(mirror_start) + (32'(pos) - 32'd2) * 32'(mirror_spc);
            link = mirror_fat[pos];
            more = is_link(link);
            rec.sector = sect[23:0];
            rec.cur = pos;
            rec.nxt = link;
            rec.empty = 1'b0;
            rec.trunc = more && (n == WALK_LIMIT - 1);
            rec.last = !more || rec.trunc;
            pending_runs.push_back(rec);
            if (!more) break;
            pos = link;
        end
    endtask

    task automatic report(input string what, input logic [23:0] want, input logic [23:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_typed_word tw;
        t_run_rec    got;
        t_run_rec    want;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DATA_START:      mirror_start = i_cfg_data;
                    CFG_CLUSTER_SECTORS: mirror_spc = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                tw = typed_q.pop_front();
                if (i_cmd == CMD_WRITE)
                    mirror_fat[i_cluster] = i_value;
                else if (tw.typed)
                    pending_runs.push_back(tw.rec);
                else
                    trace_chain(i_cluster);
            end
            if (o_valid && i_ready) begin
                got = '{sector: o_sector_address, cur: o_current_cluster,
                        nxt: o_next_cluster, empty: o_empty_res, trunc: o_truncated,
                        last: o_last};
                if (pending_runs.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %h", $time, got);
                    errors++;
                end else begin
                    want = pending_runs.pop_front();
                    report("sector_address", want.sector, got.sector);
                    report("current_cluster", 24'(want.cur), 24'(got.cur));
                    report("next_cluster", 24'(want.nxt), 24'(got.nxt));
                    report("empty_res", 24'(want.empty), 24'(got.empty));
                    report("truncated", 24'(want.trunc), 24'(got.trunc));
                    report("last", 24'(want.last), 24'(got.last));
                end
            end
        end
    end

    task automatic send_word(input logic cmd, input logic [15:0] clus, input logic [15:0] val,
                             input logic typed, input t_run_rec rec);
        while ((idle_mode == IDLE_SENDER && roll(86)) || (idle_mode == IDLE_BOTH && roll(36)))
        begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        typed_q.push_back('{typed: typed, rec: rec});
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_cluster <= clus;
        i_value <= val;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic put_entry(input logic [15:0] idx, input logic [15:0] val);
        if (!plan_known[idx]) begin
            plan_known[idx] = 1'b1;
            known_list.push_back(idx);
        end
        plan_fat[idx] = val;
        send_word(CMD_WRITE, idx, val, 1'b0, '0);
    endtask

    function automatic int unwritten_on_path(input logic [15:0] start);
        logic [15:0] c;
        c = start;
        for (int k = 0; k < WALK_LIMIT; k++) begin
            if (!is_link(c)) return -1;
            if (!plan_known[c]) return int'(c);
            c = plan_fat[c];
        end
        return -1;
    endfunction

    task automatic walk_from(input logic [15:0] start);
        int hole;
        hole = unwritten_on_path(start);
        while (hole >= 0) begin
            if (roll(70))
                put_entry(hole[15:0], 16'($urandom_range(16'hFFF8, 16'hFFFF)));
            else
                put_entry(hole[15:0], 16'($urandom_range(0, 1)));
            hole = unwritten_on_path(start);
        end
        send_word(CMD_WALK, start, 16'($urandom), 1'b0, '0);
    endtask

    function automatic logic [15:0] pick_cluster();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return MIN_CLUSTER;
        if (r < 10) return 16'hFFF7;
        return 16'($urandom_range(2, 16'hFFF7));
    endfunction

    task automatic build_and_walk();
        logic [15:0] nodes [$];
        logic [15:0] tail;
        int len;
        int r;
        len = roll(10) ? $urandom_range(62, 66) : $urandom_range(1, 8);
        for (int k = 0; k < len; k++) nodes.push_back(pick_cluster());
        r = $urandom_range(0, 99);
        if (r < 50)
            tail = 16'($urandom_range(16'hFFF8, 16'hFFFF));
        else if (r < 65)
            tail = 16'($urandom_range(0, 1));
        else if (r < 85)
            tail = nodes[$urandom_range(0, len - 1)];
        else
            tail = 16'($urandom_range(16'hFFF0, 16'hFFF7));
        for (int k = 0; k < len - 1; k++) put_entry(nodes[k], nodes[k + 1]);
        put_entry(nodes[len - 1], tail);
        walk_from(nodes[0]);
    endtask

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            build_and_walk();
        else if (r < 68)
            walk_from(known_list[$urandom_range(0, known_list.size() - 1)]);
        else if (r < 80)
            walk_from(roll(40) ? 16'($urandom_range(0, 1))
                               : 16'($urandom_range(16'hFFF8, 16'hFFFF)));
        else
            put_entry(16'($urandom), 16'($urandom));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_runs.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_geometry(input logic [19:0] first_sector, input logic [7:0] spc);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_DATA_START;
        i_cfg_data <= first_sector;
        @(negedge i_clk);
        i_cfg_index <= CFG_CLUSTER_SECTORS;
        i_cfg_data <= {12'($urandom), spc};
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        int target;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (opening_rows[i]) begin
            if (opening_rows[i].cmd == CMD_WRITE)
                put_entry(opening_rows[i].cluster, opening_rows[i].value);
            else
                send_word(CMD_WALK, opening_rows[i].cluster, opening_rows[i].value,
                          opening_rows[i].typed, opening_rows[i].rec);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain();
            case (phase)
                0: set_geometry(20'hFFFFF, 8'hFF);
                1: set_geometry(20'h00000, 8'h00);
                2: set_geometry(20'($urandom), 8'd128);
                3: set_geometry(20'($urandom), 8'($urandom_range(1, 128)));
                4: set_geometry(20'h00000, 8'd1);
                default: set_geometry(20'hFFFFF, 8'd1);
            endcase
            case (phase)
                1: idle_mode = IDLE_SENDER;
                2, 4: idle_mode = IDLE_RECEIVER;
                3: idle_mode = IDLE_BOTH;
                default: idle_mode = IDLE_NONE;
            endcase
            if (phase == 4) begin
                hold_req = hold_req + 1;
                idle_mode = IDLE_NONE;
            end
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) random_item();
        end

        drain();
        repeat (20) @(negedge i_clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== fat16_cluster_chain_walker_unit.f =====
design/fcw_pkg.sv
design/fcw_ram.sv
design/fcw_ctrl.sv
design/fcw_datapath.sv
design/fat16_cluster_chain_walker_unit.sv
design/fcw_checker.sv
tb/tb_fat16_cluster_chain_walker_unit.sv
